@@ sv/exlex_pkg.sv @@
package exlex_pkg;

	localparam int COLUMN_BITS_DEF = 16;
	localparam int LINE_BITS_DEF   = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	// width of the column and line fields on the token port
	localparam int OUT_W = 16;

	// up to four token slots per byte, at most three of them used at once
	localparam int SLOTS = 4;

	// token kinds
	localparam logic [4:0] K_PLUS    = 5'd0;
	localparam logic [4:0] K_MINUS   = 5'd1;
	localparam logic [4:0] K_RETURN  = 5'd2;
	localparam logic [4:0] K_MUL     = 5'd3;
	localparam logic [4:0] K_DIV     = 5'd4;
	localparam logic [4:0] K_LPAREN  = 5'd5;
	localparam logic [4:0] K_RPAREN  = 5'd6;
	localparam logic [4:0] K_COMMA   = 5'd7;
	localparam logic [4:0] K_EQUALS  = 5'd8;
	localparam logic [4:0] K_ISEQ    = 5'd9;
	localparam logic [4:0] K_GR      = 5'd10;
	localparam logic [4:0] K_GREQ    = 5'd11;
	localparam logic [4:0] K_LS      = 5'd12;
	localparam logic [4:0] K_LSEQ    = 5'd13;
	localparam logic [4:0] K_INT     = 5'd14;
	localparam logic [4:0] K_FLOAT   = 5'd15;
	localparam logic [4:0] K_KEYWORD = 5'd16;
	localparam logic [4:0] K_IDENT   = 5'd17;
	localparam logic [4:0] K_EOF     = 5'd18;

	localparam int         NUM_KW = 12;
	localparam logic [3:0] NO_KW  = 4'd12;

	// keywords, left aligned, zero padded to eight bytes
	localparam logic [63:0] KW_TEXT [NUM_KW] = '{
		{"VAR", 40'd0}, {"AND", 40'd0}, {"OR", 48'd0}, {"NOT", 40'd0},
		{"IF", 48'd0}, {"ELIF", 32'd0}, {"ELSE", 32'd0}, {"FOR", 40'd0},
		{"WHILE", 24'd0}, {"TO", 48'd0}, {"STEP", 32'd0}, {"FUNC", 32'd0}
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{
		3'd3, 3'd3, 3'd2, 3'd3, 3'd2, 3'd4, 3'd4, 3'd3, 3'd5, 3'd2, 3'd4, 3'd4
	};

	// character codes
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;

	typedef struct packed {
		logic [4:0]       kind;
		logic [3:0]       kw_idx;
		logic [OUT_W-1:0] start_col;
		logic [OUT_W-1:0] end_col;
		logic [OUT_W-1:0] line_no;
		logic             illegal;
	} tok_t;

	typedef struct packed {
		logic [SLOTS-1:0] mask;
		tok_t [SLOTS-1:0] tok;
	} bundle_t;

	function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] pos);
		logic [63:0] w;
		w = KW_TEXT[k];
		return w[63 - 8*pos -: 8];
	endfunction

	function automatic logic is_digit(input logic [7:0] ch);
		return (ch >= CH_0) && (ch <= CH_9);
	endfunction

	function automatic logic is_letter(input logic [7:0] ch);
		return ((ch >= CH_UA) && (ch <= CH_UZ)) || ((ch >= CH_LA) && (ch <= CH_LZ));
	endfunction

endpackage

@@ sv/exlex_front.sv @@
module exlex_front #(
	parameter int COLUMN_BITS = exlex_pkg::COLUMN_BITS_DEF,
	parameter int LINE_BITS   = exlex_pkg::LINE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               text_valid,
	output logic               text_ready,
	input  logic [7:0]         text_byte,
	input  logic               end_of_text,
	input  logic               q_full,
	output logic               q_push,
	output exlex_pkg::bundle_t q_data
);

	localparam logic [2:0] M_IDLE  = 3'd0;
	localparam logic [2:0] M_MINUS = 3'd1;
	localparam logic [2:0] M_EQ    = 3'd2;
	localparam logic [2:0] M_GR    = 3'd3;
	localparam logic [2:0] M_LS    = 3'd4;
	localparam logic [2:0] M_NUM   = 3'd5;
	localparam logic [2:0] M_WORD  = 3'd6;
	localparam logic [2:0] M_STOP  = 3'd7;

	localparam int OW = exlex_pkg::OUT_W;

	logic [2:0]             mode_q, mode_n;
	logic [COLUMN_BITS-1:0] start_q, start_n;
	logic [COLUMN_BITS-1:0] col_q, col_n;
	logic [LINE_BITS-1:0]   line_q, line_n;
	logic [11:0]            cands_q, cands_n;
	logic [2:0]             wlen_q, wlen_n;
	logic                   dot_q, dot_n;

	logic                   used;
	logic                   op_hit;
	logic [4:0]             op_kind;
	logic [14:0]            ws;
	exlex_pkg::bundle_t     bundle;
	logic                   accept;

	function automatic logic [COLUMN_BITS-1:0] col_inc(input logic [COLUMN_BITS-1:0] c);
		return (c == '1) ? c : c + COLUMN_BITS'(1);
	endfunction

	function automatic exlex_pkg::tok_t mk_tok(
		input logic [4:0]             kind,
		input logic [3:0]             kw,
		input logic [COLUMN_BITS-1:0] s,
		input logic [COLUMN_BITS-1:0] e,
		input logic                   ill,
		input logic [LINE_BITS-1:0]   ln
	);
		exlex_pkg::tok_t t;
		t.kind      = kind;
		t.kw_idx    = kw;
		t.start_col = OW'(s);
		t.end_col   = OW'(e);
		t.line_no   = OW'(ln);
		t.illegal   = ill;
		return t;
	endfunction

	// candidates in [14:3], length in [2:0]
	function automatic logic [14:0] word_step(
		input logic [11:0] cands,
		input logic [2:0]  len,
		input logic [7:0]  ch
	);
		logic [11:0] c;
		logic [2:0]  l;
		c = cands;
		for (int k = 0; k < exlex_pkg::NUM_KW; k++) begin
			if (exlex_pkg::kw_char(4'(k), len) != ch) c[k] = 1'b0;
		end
		l = (len < 3'd7) ? len + 3'd1 : len;
		return {c, l};
	endfunction

	function automatic logic flush_has(input logic [2:0] mode);
		return (mode == M_MINUS) || (mode == M_EQ) || (mode == M_GR) || (mode == M_LS) ||
			(mode == M_NUM) || (mode == M_WORD);
	endfunction

	function automatic exlex_pkg::tok_t flush_tok(
		input logic [2:0]             mode,
		input logic [COLUMN_BITS-1:0] s,
		input logic [COLUMN_BITS-1:0] c,
		input logic                   dot,
		input logic [11:0]            cands,
		input logic [2:0]             len,
		input logic [LINE_BITS-1:0]   ln
	);
		logic [COLUMN_BITS-1:0] run_end;
		logic [3:0]             idx;
		exlex_pkg::tok_t        t;
		run_end = (c > s) ? c - COLUMN_BITS'(1) : s;
		idx = exlex_pkg::NO_KW;
		// first matching keyword wins
		for (int k = exlex_pkg::NUM_KW - 1; k >= 0; k--) begin
			if (cands[k] && (exlex_pkg::KW_LEN[k] == len)) idx = 4'(k);
		end
		unique case (mode)
			M_MINUS: t = mk_tok(exlex_pkg::K_MINUS, exlex_pkg::NO_KW, s, s, 1'b0, ln);
			M_EQ:    t = mk_tok(exlex_pkg::K_EQUALS, exlex_pkg::NO_KW, s, s, 1'b0, ln);
			M_GR:    t = mk_tok(exlex_pkg::K_GR, exlex_pkg::NO_KW, s, s, 1'b0, ln);
			M_LS:    t = mk_tok(exlex_pkg::K_LS, exlex_pkg::NO_KW, s, s, 1'b0, ln);
			M_NUM:   t = mk_tok(dot ? exlex_pkg::K_FLOAT : exlex_pkg::K_INT,
					exlex_pkg::NO_KW, s, run_end, 1'b0, ln);
			M_WORD:  t = mk_tok((idx == exlex_pkg::NO_KW) ? exlex_pkg::K_IDENT
					: exlex_pkg::K_KEYWORD, idx, s, run_end, 1'b0, ln);
			default: t = mk_tok(exlex_pkg::K_EOF, exlex_pkg::NO_KW, s, s, 1'b0, ln);
		endcase
		return t;
	endfunction

	assign text_ready = !q_full;
	assign accept     = text_valid && text_ready;
	assign q_push     = accept && (|bundle.mask);
	assign q_data     = bundle;

	always_comb begin
		mode_n  = mode_q;
		start_n = start_q;
		col_n   = col_q;
		line_n  = line_q;
		cands_n = cands_q;
		wlen_n  = wlen_q;
		dot_n   = dot_q;
		bundle  = '0;
		used    = 1'b0;
		op_hit  = 1'b0;
		op_kind = exlex_pkg::K_PLUS;
		ws      = '0;
		if (mode_q == M_STOP) begin
			// drop bytes until the end of the text
			if (end_of_text) begin
				mode_n  = M_IDLE;
				start_n = '0;
				col_n   = '0;
				line_n  = '0;
				cands_n = '1;
				wlen_n  = '0;
				dot_n   = 1'b0;
			end
		end else begin
			unique case (mode_q)
				M_MINUS: begin
					if (text_byte == exlex_pkg::CH_GT) begin
						bundle.mask[0] = 1'b1;
						bundle.tok[0]  = mk_tok(exlex_pkg::K_RETURN, exlex_pkg::NO_KW,
							start_q, col_q, 1'b0, line_q);
						col_n  = col_inc(col_q);
						mode_n = M_IDLE;
						used   = 1'b1;
					end
				end
				M_EQ, M_GR, M_LS: begin
					if (text_byte == exlex_pkg::CH_EQ) begin
						bundle.mask[0] = 1'b1;
						bundle.tok[0]  = mk_tok((mode_q == M_EQ) ? exlex_pkg::K_ISEQ :
							((mode_q == M_GR) ? exlex_pkg::K_GREQ : exlex_pkg::K_LSEQ),
							exlex_pkg::NO_KW, start_q, col_q, 1'b0, line_q);
						col_n  = col_inc(col_q);
						mode_n = M_IDLE;
						used   = 1'b1;
					end
				end
				M_NUM: begin
					if (exlex_pkg::is_digit(text_byte) || (text_byte == exlex_pkg::CH_DOT)) begin
						if (text_byte == exlex_pkg::CH_DOT) dot_n = 1'b1;
						col_n = col_inc(col_q);
						used  = 1'b1;
					end
				end
				M_WORD: begin
					if (exlex_pkg::is_letter(text_byte)) begin
						ws      = word_step(cands_q, wlen_q, text_byte);
						cands_n = ws[14:3];
						wlen_n  = ws[2:0];
						col_n   = col_inc(col_q);
						used    = 1'b1;
					end
				end
				default: ;
			endcase

			if (!used) begin
				// flush the pending token, then take the byte fresh
				bundle.mask[0] = flush_has(mode_q);
				bundle.tok[0]  = flush_tok(mode_q, start_q, col_q, dot_q, cands_q, wlen_q,
					line_q);
				mode_n = M_IDLE;
				unique case (text_byte)
					exlex_pkg::CH_PLUS: begin
						op_hit  = 1'b1;
						op_kind = exlex_pkg::K_PLUS;
					end
					exlex_pkg::CH_STAR: begin
						op_hit  = 1'b1;
						op_kind = exlex_pkg::K_MUL;
					end
					exlex_pkg::CH_SLASH: begin
						op_hit  = 1'b1;
						op_kind = exlex_pkg::K_DIV;
					end
					exlex_pkg::CH_LPAREN: begin
						op_hit  = 1'b1;
						op_kind = exlex_pkg::K_LPAREN;
					end
					exlex_pkg::CH_RPAREN: begin
						op_hit  = 1'b1;
						op_kind = exlex_pkg::K_RPAREN;
					end
					exlex_pkg::CH_COMMA: begin
						op_hit  = 1'b1;
						op_kind = exlex_pkg::K_COMMA;
					end
					exlex_pkg::CH_MINUS: begin
						start_n = col_q;
						col_n   = col_inc(col_q);
						mode_n  = M_MINUS;
					end
					exlex_pkg::CH_EQ: begin
						start_n = col_q;
						col_n   = col_inc(col_q);
						mode_n  = M_EQ;
					end
					exlex_pkg::CH_GT: begin
						start_n = col_q;
						col_n   = col_inc(col_q);
						mode_n  = M_GR;
					end
					exlex_pkg::CH_LT: begin
						start_n = col_q;
						col_n   = col_inc(col_q);
						mode_n  = M_LS;
					end
					exlex_pkg::CH_SPACE: begin
						col_n = col_inc(col_q);
					end
					exlex_pkg::CH_LF: begin
						col_n  = '0;
						line_n = (line_q == '1) ? line_q : line_q + LINE_BITS'(1);
					end
					default: begin
						if (exlex_pkg::is_digit(text_byte)) begin
							start_n = col_q;
							dot_n   = 1'b0;
							col_n   = col_inc(col_q);
							mode_n  = M_NUM;
						end else if (exlex_pkg::is_letter(text_byte)) begin
							start_n = col_q;
							ws      = word_step('1, 3'd0, text_byte);
							cands_n = ws[14:3];
							wlen_n  = ws[2:0];
							col_n   = col_inc(col_q);
							mode_n  = M_WORD;
						end else begin
							bundle.mask[1] = 1'b1;
							bundle.tok[1]  = mk_tok(exlex_pkg::K_EOF, exlex_pkg::NO_KW,
								col_q, col_q, 1'b1, line_q);
							mode_n = M_STOP;
						end
					end
				endcase
				if (op_hit) begin
					bundle.mask[1] = 1'b1;
					bundle.tok[1]  = mk_tok(op_kind, exlex_pkg::NO_KW, col_q, col_q, 1'b0,
						line_q);
					col_n = col_inc(col_q);
				end
			end

			if (end_of_text) begin
				if (mode_n != M_STOP) begin
					bundle.mask[2] = flush_has(mode_n);
					bundle.tok[2]  = flush_tok(mode_n, start_n, col_n, dot_n, cands_n, wlen_n,
						line_n);
					bundle.mask[3] = 1'b1;
					bundle.tok[3]  = mk_tok(exlex_pkg::K_EOF, exlex_pkg::NO_KW, col_n, col_n,
						1'b0, line_n);
				end
				mode_n  = M_IDLE;
				start_n = '0;
				col_n   = '0;
				line_n  = '0;
				cands_n = '1;
				wlen_n  = '0;
				dot_n   = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			start_q <= '0;
			col_q   <= '0;
			line_q  <= '0;
			cands_q <= '1;
			wlen_q  <= '0;
			dot_q   <= 1'b0;
		end else if (accept) begin
			mode_q  <= mode_n;
			start_q <= start_n;
			col_q   <= col_n;
			line_q  <= line_n;
			cands_q <= cands_n;
			wlen_q  <= wlen_n;
			dot_q   <= dot_n;
		end
	end

endmodule

@@ sv/exlex_queue.sv @@
module exlex_queue #(
	parameter int DEPTH = exlex_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  exlex_pkg::bundle_t push_data,
	input  logic               pop,
	output exlex_pkg::bundle_t pop_data,
	output logic               full,
	output logic               empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	exlex_pkg::bundle_t mem_q [DEPTH];
	logic [PW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]      count_q;
	logic               do_push, do_pop;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (do_pop) rd_ptr_q <= ptr_next(rd_ptr_q);
			if (do_push && !do_pop) count_q <= count_q + CW'(1);
			else if (do_pop && !do_push) count_q <= count_q - CW'(1);
		end
	end

endmodule

@@ sv/exlex_back.sv @@
module exlex_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_empty,
	input  exlex_pkg::bundle_t                q_data,
	output logic                              q_pop,
	output logic                              token_valid,
	input  logic                              token_ready,
	output logic [4:0]                        token_kind,
	output logic [3:0]                        keyword_index,
	output logic [exlex_pkg::OUT_W-1:0]       start_column,
	output logic [exlex_pkg::OUT_W-1:0]       end_column,
	output logic [exlex_pkg::OUT_W-1:0]       line_number,
	output logic                              illegal_stop,
	output logic                              last_of_run
);

	localparam int SW = $clog2(exlex_pkg::SLOTS);

	exlex_pkg::bundle_t         cur_q;
	logic [exlex_pkg::SLOTS-1:0] rem_q;
	logic [exlex_pkg::SLOTS-1:0] rem_left;
	logic [SW-1:0]              sel;
	exlex_pkg::tok_t            tok;
	logic                       take;
	logic                       done;

	// lowest pending slot goes out first
	always_comb begin
		sel = '0;
		for (int i = exlex_pkg::SLOTS - 1; i >= 0; i--) begin
			if (rem_q[i]) sel = SW'(i);
		end
	end

	always_comb begin
		rem_left      = rem_q;
		rem_left[sel] = 1'b0;
	end

	assign tok         = cur_q.tok[sel];
	assign token_valid = |rem_q;
	assign take        = token_valid && token_ready;
	assign last_of_run = (rem_left == '0);
	assign done        = !token_valid || (take && last_of_run);
	assign q_pop       = done && !q_empty;

	assign token_kind    = tok.kind;
	assign keyword_index = tok.kw_idx;
	assign start_column  = tok.start_col;
	assign end_column    = tok.end_col;
	assign line_number   = tok.line_no;
	assign illegal_stop  = tok.illegal;

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (q_pop) begin
			rem_q <= q_data.mask;
		end else if (take) begin
			rem_q <= rem_left;
		end
	end

endmodule

@@ sv/expression_lexer.sv @@
// Streaming lexer: takes one text byte per transaction and returns its tokens
// (kind, keyword index, start and end column, line, error flag) one per
// transaction, with last_of_run on the final token of each byte. A byte is
// taken every cycle while the token queue (QUEUE_DEPTH entries, one per byte
// that yields tokens) has room; each byte yields zero to three tokens, and
// the token port sends one token per cycle while token_ready is high, so
// sustained byte rate is one per cycle as long as bytes average at most one
// token and the sink does not stall. The queue entry is written on the taking
// edge; the output register loads it once the previous byte's tokens are all
// taken and then offers its first token. Column and line counters saturate
// at all ones in COLUMN_BITS and LINE_BITS bits; fields carry the low 16 bits.
module expression_lexer #(
	parameter int COLUMN_BITS = exlex_pkg::COLUMN_BITS_DEF,
	parameter int LINE_BITS   = exlex_pkg::LINE_BITS_DEF,
	parameter int QUEUE_DEPTH = exlex_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        text_valid,
	output logic                        text_ready,
	input  logic [7:0]                  text_byte,
	input  logic                        end_of_text,
	output logic                        token_valid,
	input  logic                        token_ready,
	output logic [4:0]                  token_kind,
	output logic [3:0]                  keyword_index,
	output logic [exlex_pkg::OUT_W-1:0] start_column,
	output logic [exlex_pkg::OUT_W-1:0] end_column,
	output logic [exlex_pkg::OUT_W-1:0] line_number,
	output logic                        illegal_stop,
	output logic                        last_of_run
);

	logic               q_full, q_empty, q_push, q_pop;
	exlex_pkg::bundle_t q_in, q_out;

	exlex_front #(
		.COLUMN_BITS(COLUMN_BITS),
		.LINE_BITS  (LINE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_ready (text_ready),
		.text_byte  (text_byte),
		.end_of_text(end_of_text),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_in)
	);

	exlex_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_in),
		.pop      (q_pop),
		.pop_data (q_out),
		.full     (q_full),
		.empty    (q_empty)
	);

	exlex_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_data       (q_out),
		.q_pop        (q_pop),
		.token_valid  (token_valid),
		.token_ready  (token_ready),
		.token_kind   (token_kind),
		.keyword_index(keyword_index),
		.start_column (start_column),
		.end_column   (end_column),
		.line_number  (line_number),
		.illegal_stop (illegal_stop),
		.last_of_run  (last_of_run)
	);

endmodule

@@ tb/tb_expression_lexer.sv @@
`timescale 1ns / 100ps

module tb_expression_lexer;

	localparam int unsigned COL_MAX  = (1 << exlex_pkg::COLUMN_BITS_DEF) - 1;
	localparam int unsigned LINE_MAX = (1 << exlex_pkg::LINE_BITS_DEF) - 1;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam int PHASE_BYTES = 45;

	typedef enum logic [2:0] {
		LX_IDLE, LX_MINUS, LX_EQ, LX_GR, LX_LS, LX_NUM, LX_WORD, LX_STOP
	} lex_mode_t;

	typedef struct {
		logic [4:0]                  kind;
		logic [3:0]                  kw;
		logic [exlex_pkg::OUT_W-1:0] scol;
		logic [exlex_pkg::OUT_W-1:0] ecol;
		logic [exlex_pkg::OUT_W-1:0] line;
		logic                        ill;
		logic                        last;
	} token_t;

	class token_scoreboard;
		lex_mode_t   mode;
		int unsigned tok_start;
		int unsigned column;
		int unsigned line_cnt;
		logic [11:0] cand;
		logic [2:0]  word_len;
		logic        saw_dot;
		token_t      step_q[$];
		token_t      expected_tokens[$];
		int          errors;
		int          checked;

		function new();
			errors = 0;
			checked = 0;
			restart();
		endfunction

		function void restart();
			mode = LX_IDLE;
			tok_start = 0;
			column = 0;
			line_cnt = 0;
			cand = '1;
			word_len = '0;
			saw_dot = 1'b0;
		endfunction

		function void bump_col();
			if (column < COL_MAX) column++;
		endfunction

		function void emit(logic [4:0] k, logic [3:0] kw, int unsigned s, int unsigned e,
				logic ill);
			token_t t;
			t.kind = k;
			t.kw = kw;
			t.scol = s[exlex_pkg::OUT_W-1:0];
			t.ecol = e[exlex_pkg::OUT_W-1:0];
			t.line = line_cnt[exlex_pkg::OUT_W-1:0];
			t.ill = ill;
			t.last = 1'b0;
			step_q.insert(step_q.size(), t);
		endfunction

		function int unsigned run_end();
			return (column > tok_start) ? column - 1 : tok_start;
		endfunction

		function void take_letter(logic [7:0] b);
			logic [63:0] w;
			for (int k = 0; k < exlex_pkg::NUM_KW; k++) begin
				w = exlex_pkg::KW_TEXT[k];
				if (w[63 - 8 * int'(word_len) -: 8] != b) cand[k] = 1'b0;
			end
			if (word_len < 7) word_len++;
		endfunction

		function void flush_pending();
			logic [3:0] idx;
			case (mode)
				LX_MINUS: emit(exlex_pkg::K_MINUS, exlex_pkg::NO_KW, tok_start, tok_start,
					1'b0);
				LX_EQ:    emit(exlex_pkg::K_EQUALS, exlex_pkg::NO_KW, tok_start, tok_start,
					1'b0);
				LX_GR:    emit(exlex_pkg::K_GR, exlex_pkg::NO_KW, tok_start, tok_start, 1'b0);
				LX_LS:    emit(exlex_pkg::K_LS, exlex_pkg::NO_KW, tok_start, tok_start, 1'b0);
				LX_NUM:   emit(saw_dot ? exlex_pkg::K_FLOAT : exlex_pkg::K_INT,
					exlex_pkg::NO_KW, tok_start, run_end(), 1'b0);
				LX_WORD: begin
					idx = exlex_pkg::NO_KW;
					for (int k = 0; k < exlex_pkg::NUM_KW; k++) begin
						if (cand[k] && exlex_pkg::KW_LEN[k] == word_len) begin
							idx = 4'(k);
							break;
						end
					end
					emit(idx == exlex_pkg::NO_KW ? exlex_pkg::K_IDENT : exlex_pkg::K_KEYWORD,
						idx, tok_start, run_end(), 1'b0);
				end
				default: ;
			endcase
			if (mode != LX_STOP) mode = LX_IDLE;
		endfunction

		function void single_op(logic [4:0] k);
			emit(k, exlex_pkg::NO_KW, column, column, 1'b0);
			bump_col();
		endfunction

		function void open_pair(lex_mode_t m);
			tok_start = column;
			bump_col();
			mode = m;
		endfunction

		// Lex one accepted byte; returns 1 when the byte was skipped after an error stop.
		function bit lex_byte(logic [7:0] b, logic eot);
			bit used;
			bit digit;
			bit letter;
			used = 0;
			digit = (b >= exlex_pkg::CH_0) && (b <= exlex_pkg::CH_9);
			letter = ((b >= exlex_pkg::CH_UA) && (b <= exlex_pkg::CH_UZ)) ||
				((b >= exlex_pkg::CH_LA) && (b <= exlex_pkg::CH_LZ));
			step_q.delete();
			if (mode == LX_STOP) begin
				if (eot) restart();
				return 1;
			end
			case (mode)
				LX_MINUS: if (b == exlex_pkg::CH_GT) begin
					emit(exlex_pkg::K_RETURN, exlex_pkg::NO_KW, tok_start, column, 1'b0);
					bump_col();
					mode = LX_IDLE;
					used = 1;
				end
				LX_EQ, LX_GR, LX_LS: if (b == exlex_pkg::CH_EQ) begin
					emit(mode == LX_EQ ? exlex_pkg::K_ISEQ :
						(mode == LX_GR ? exlex_pkg::K_GREQ : exlex_pkg::K_LSEQ),
						exlex_pkg::NO_KW, tok_start, column, 1'b0);
					bump_col();
					mode = LX_IDLE;
					used = 1;
				end
				LX_NUM: if (digit || b == exlex_pkg::CH_DOT) begin
					if (b == exlex_pkg::CH_DOT) saw_dot = 1'b1;
					bump_col();
					used = 1;
				end
				LX_WORD: if (letter) begin
					take_letter(b);
					bump_col();
					used = 1;
				end
				default: ;
			endcase
			if (!used) begin
				flush_pending();
				case (b)
					exlex_pkg::CH_PLUS:   single_op(exlex_pkg::K_PLUS);
					exlex_pkg::CH_STAR:   single_op(exlex_pkg::K_MUL);
					exlex_pkg::CH_SLASH:  single_op(exlex_pkg::K_DIV);
					exlex_pkg::CH_LPAREN: single_op(exlex_pkg::K_LPAREN);
					exlex_pkg::CH_RPAREN: single_op(exlex_pkg::K_RPAREN);
					exlex_pkg::CH_COMMA:  single_op(exlex_pkg::K_COMMA);
					exlex_pkg::CH_MINUS:  open_pair(LX_MINUS);
					exlex_pkg::CH_EQ:     open_pair(LX_EQ);
					exlex_pkg::CH_GT:     open_pair(LX_GR);
					exlex_pkg::CH_LT:     open_pair(LX_LS);
					exlex_pkg::CH_SPACE:  bump_col();
					exlex_pkg::CH_LF: begin
						column = 0;
						if (line_cnt < LINE_MAX) line_cnt++;
					end
					default: begin
						if (digit) begin
							saw_dot = 1'b0;
							open_pair(LX_NUM);
						end else if (letter) begin
							tok_start = column;
							cand = '1;
							word_len = '0;
							take_letter(b);
							bump_col();
							mode = LX_WORD;
						end else begin
							emit(exlex_pkg::K_EOF, exlex_pkg::NO_KW, column, column, 1'b1);
							mode = LX_STOP;
						end
					end
				endcase
			end
			if (eot) begin
				if (mode != LX_STOP) begin
					flush_pending();
					emit(exlex_pkg::K_EOF, exlex_pkg::NO_KW, column, column, 1'b0);
				end
				restart();
			end
			if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
			foreach (step_q[i]) expected_tokens.insert(expected_tokens.size(), step_q[i]);
			return 0;
		endfunction

		function string tok_str(token_t t);
			return $sformatf("kind=%0d kw=%0d cols=%0d..%0d line=%0d ill=%0b last=%0b",
				t.kind, t.kw, t.scol, t.ecol, t.line, t.ill, t.last);
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 10) $display("[%0t] ERROR %s", $realtime, msg);
		endfunction

		function void check_token(token_t got);
			token_t exp;
			if (expected_tokens.size() == 0) begin
				report({"unexpected token: ", tok_str(got)});
				return;
			end
			exp = expected_tokens.pop_front();
			checked++;
			if (got.kind !== exp.kind || got.kw !== exp.kw || got.scol !== exp.scol ||
					got.ecol !== exp.ecol || got.line !== exp.line || got.ill !== exp.ill ||
					got.last !== exp.last)
				report({"token mismatch\n  expected ", tok_str(exp), "\n  actual   ", tok_str(got)});
		endfunction

		function int outstanding();
			return expected_tokens.size();
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        text_valid = 1'b0;
	logic                        text_ready;
	logic [7:0]                  text_byte = 8'h00;
	logic                        end_of_text = 1'b0;
	logic                        token_valid;
	logic                        token_ready = 1'b0;
	logic [4:0]                  token_kind;
	logic [3:0]                  keyword_index;
	logic [exlex_pkg::OUT_W-1:0] start_column;
	logic [exlex_pkg::OUT_W-1:0] end_column;
	logic [exlex_pkg::OUT_W-1:0] line_number;
	logic                        illegal_stop;
	logic                        last_of_run;

	token_scoreboard sb = new();
	int idle_pct = 0;
	int stall_pct = 0;
	int bytes_sent = 0;
	int bytes_skipped = 0;
	int texts_sent = 0;

	expression_lexer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_ready   (text_ready),
		.text_byte    (text_byte),
		.end_of_text  (end_of_text),
		.token_valid  (token_valid),
		.token_ready  (token_ready),
		.token_kind   (token_kind),
		.keyword_index(keyword_index),
		.start_column (start_column),
		.end_column   (end_column),
		.line_number  (line_number),
		.illegal_stop (illegal_stop),
		.last_of_run  (last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// token sink: check each transaction, then pick ready for the next cycle
	always @(posedge clk) begin
		token_t got;
		if (arst_n) begin
			if (token_valid && token_ready) begin
				got.kind = token_kind;
				got.kw = keyword_index;
				got.scol = start_column;
				got.ecol = end_column;
				got.line = line_number;
				got.ill = illegal_stop;
				got.last = last_of_run;
				sb.check_token(got);
			end
			token_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic eot);
		int gap;
		gap = 0;
		while (idle_pct != 0 && gap < 40 && $urandom_range(99) < idle_pct) gap++;
		if (gap > 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_valid <= 1'b1;
		text_byte <= b;
		end_of_text <= eot;
		@(posedge clk);
		while (!text_ready) @(posedge clk);
		if (sb.lex_byte(b, eot)) bytes_skipped++;
		else bytes_sent++;
	endtask

	task automatic send_text(input logic [7:0] txt[$]);
		foreach (txt[i]) push_byte(txt[i], i == txt.size() - 1);
		texts_sent++;
	endtask

	task automatic send_string(input string s);
		logic [7:0] txt[$];
		for (int i = 0; i < s.len(); i++) txt.insert(txt.size(), s[i]);
		send_text(txt);
	endtask

	// mostly well-formed source with random content; some texts broken or pure noise
	task automatic make_text(output logic [7:0] txt[$]);
		logic [7:0] singles[6];
		logic [7:0] pair_lead[4];
		logic [7:0] bad;
		logic [63:0] w;
		int n;
		int len;
		int k;
		singles = '{exlex_pkg::CH_PLUS, exlex_pkg::CH_STAR, exlex_pkg::CH_SLASH,
			exlex_pkg::CH_LPAREN, exlex_pkg::CH_RPAREN, exlex_pkg::CH_COMMA};
		pair_lead = '{exlex_pkg::CH_MINUS, exlex_pkg::CH_EQ, exlex_pkg::CH_GT,
			exlex_pkg::CH_LT};
		txt.delete();
		if ($urandom_range(99) < 8) begin
			repeat ($urandom_range(6, 1)) txt.insert(txt.size(), 8'($urandom_range(255)));
			return;
		end
		n = $urandom_range(12, 3);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(11))
				0, 10: txt.insert(txt.size(), singles[$urandom_range(5)]);
				1: begin
					txt.insert(txt.size(), pair_lead[$urandom_range(3)]);
					case ($urandom_range(2))
						1: txt.insert(txt.size(), exlex_pkg::CH_EQ);
						2: txt.insert(txt.size(), exlex_pkg::CH_GT);
						default: ;
					endcase
				end
				2, 3: begin
					txt.insert(txt.size(), exlex_pkg::CH_0 + 8'($urandom_range(9)));
					len = $urandom_range(5);
					repeat (len) txt.insert(txt.size(), ($urandom_range(3) == 0)
						? exlex_pkg::CH_DOT : exlex_pkg::CH_0 + 8'($urandom_range(9)));
				end
				4, 5: begin
					k = $urandom_range(exlex_pkg::NUM_KW - 1);
					w = exlex_pkg::KW_TEXT[k];
					for (int p = 0; p < exlex_pkg::KW_LEN[k]; p++)
						txt.insert(txt.size(), w[63 - 8 * p -: 8]);
					case ($urandom_range(5))
						0: txt[txt.size() - 1] = txt[txt.size() - 1] ^ 8'h20;
						1: txt.insert(txt.size(), exlex_pkg::CH_UA + 8'($urandom_range(25)));
						default: ;
					endcase
				end
				6: begin
					len = $urandom_range(9, 1);
					repeat (len) txt.insert(txt.size(), ($urandom_range(1) ? exlex_pkg::CH_UA
						: exlex_pkg::CH_LA) + 8'($urandom_range(25)));
				end
				7, 8: txt.insert(txt.size(), exlex_pkg::CH_SPACE);
				9: txt.insert(txt.size(), exlex_pkg::CH_LF);
				default: txt.insert(txt.size(), ($urandom_range(9) < 3)
					? 8'($urandom_range(255)) : exlex_pkg::CH_SPACE);
			endcase
		end
		if ($urandom_range(99) < 12) begin
			case ($urandom_range(3))
				0: bad = CH_TAB;
				1: bad = CH_CR;
				2: bad = exlex_pkg::CH_DOT;
				default: bad = 8'h80 + 8'($urandom_range(127));
			endcase
			txt.insert($urandom_range(txt.size()), bad);
			repeat ($urandom_range(3, 1)) txt.insert(txt.size(), 8'($urandom_range(255)));
		end
	endtask

	task automatic run_phase(input int idle, input int stall);
		logic [7:0] txt[$];
		int start;
		idle_pct = idle;
		stall_pct = stall;
		start = bytes_sent + bytes_skipped;
		while (bytes_sent + bytes_skipped - start < PHASE_BYTES) begin
			make_text(txt);
			send_text(txt);
		end
	endtask

	initial begin
		logic [7:0] txt[$];
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every operator, the lone lookahead bytes, float/int/keyword/ident
		send_string("+*/(),->==>=<=-=><");
		send_string("7.5 IF 3\na");
		// error stop mid-text: later bytes are dropped up to end of text
		txt = '{exlex_pkg::CH_LA, 8'hFF, exlex_pkg::CH_LA, exlex_pkg::CH_0};
		send_text(txt);
		txt = '{8'h00};
		send_text(txt);

		run_phase(0, 0);
		run_phase(81, 0);
		run_phase(0, 81);
		run_phase(13, 13);

		text_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("tb: %0d texts, %0d bytes lexed, %0d dropped after error stops",
			texts_sent, bytes_sent, bytes_skipped);
		$display("tb: %0d tokens checked across operators, numbers, words and stops, %0d errors",
			sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

@@ files.f @@
sv/exlex_pkg.sv
sv/exlex_front.sv
sv/exlex_queue.sv
sv/exlex_back.sv
sv/expression_lexer.sv
tb/tb_expression_lexer.sv
